// ----- sv/tscfe_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the timestamped COBS frame encoder.
package tscfe_pkg;

   // Request: one payload byte with packet marks and the millisecond count.
   typedef struct packed {
      logic        first_byte;
      logic        last_byte;
      logic [7:0]  data_byte;
      logic [31:0] now_ms;
   } tscfe_req_type;

   // Response: up to eight encoded bytes, earliest byte in the low lane.
   typedef struct packed {
      logic [63:0] frame_bytes;
      logic [3:0]  byte_count;
      logic        frame_end;
      logic        last_result;
   } tscfe_rsp_type;

   // Queue entry from the front end: a classified request with its timestamp.
   typedef struct packed {
      logic        first;
      logic        last;
      logic [7:0]  data;
      logic [63:0] stamp;
   } tscfe_entry_type;

   // One encoder symbol handed from the back end to the packer.
   typedef struct packed {
      logic       valid;
      logic       has_byte;
      logic [7:0] value;
      logic       step_end;
      logic       frame_end;
   } tscfe_sym_type;

   typedef enum logic [1:0] {
      ST_PUSH,
      ST_BODY,
      ST_FIN,
      ST_DELIM
   } tscfe_state_type;

   localparam int         RUN_DEPTH   = 254;
   localparam logic [7:0] RUN_MAX     = 8'd254;
   localparam logic [7:0] RUN_LAST    = 8'd253;
   localparam logic [7:0] DELIM_BYTE  = 8'h00;
   localparam logic [7:0] FULL_CODE   = 8'hFF;
   localparam logic [3:0] POS_DATA    = 4'd8;
   localparam logic [3:0] POS_START   = 4'hF;
   localparam logic [3:0] CHUNK_BYTES = 4'd8;

endpackage

// ----- sv/tscfe_front.sv -----
`timescale 1ns / 1ps
// Front end: offset register, packet tracking and timestamp formation.
module tscfe_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  tscfe_pkg::tscfe_req_type   req_payload,
   output logic                       req_stall,
   input  logic                       csr_write_en,
   input  logic signed [63:0]         csr_write_data,
   input  logic                       q_full,
   output logic                       q_push,
   output tscfe_pkg::tscfe_entry_type q_entry
);
   import tscfe_pkg::*;

   logic [63:0] offset_ff;
   logic        in_frame_ff;
   logic        in_frame_in;
   logic        accept;
   logic        open;
   logic        offset_on;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign offset_on = (offset_ff != 64'd0);

   // A first byte opens a packet only while the offset is nonzero; the
   // decision holds until the packet's last byte.
   assign open        = req_payload.first_byte ? offset_on : in_frame_ff;
   assign in_frame_in = accept ? (open && !req_payload.last_byte) : in_frame_ff;

   assign q_push        = accept && open;
   assign q_entry.first = req_payload.first_byte;
   assign q_entry.last  = req_payload.last_byte;
   assign q_entry.data  = req_payload.data_byte;
   assign q_entry.stamp = offset_ff + {32'd0, req_payload.now_ms};

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= 64'd0;
         in_frame_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            offset_ff <= $unsigned(csr_write_data);
         end
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

// ----- sv/tscfe_fifo.sv -----
`timescale 1ns / 1ps
// Short queue between the front end and the encoder back end.
module tscfe_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tscfe_pkg::tscfe_entry_type push_entry,
   output logic                       full,
   input  logic                       pop,
   output logic                       head_valid,
   output tscfe_pkg::tscfe_entry_type head
);
   import tscfe_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   tscfe_entry_type  entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- sv/tscfe_back.sv -----
`timescale 1ns / 1ps
// Encoder back end: byte sequencer, run store and COBS group flushing.
module tscfe_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fifo_valid,
   input  tscfe_pkg::tscfe_entry_type head,
   output logic                       pop,
   input  logic                       pack_ready,
   output tscfe_pkg::tscfe_sym_type   sym
);
   import tscfe_pkg::*;

   tscfe_state_type state_ff, state_in;
   logic [3:0] pos_ff, pos_in;
   logic [7:0] run_len_ff, run_len_in;
   logic       full_sent_ff, full_sent_in;
   logic [7:0] flush_n_ff, flush_n_in;
   logic [7:0] rd_idx_ff, rd_idx_in;
   logic       fin_ff, fin_in;
   logic [7:0] rd_data_ff;

   logic [7:0] run_mem [RUN_DEPTH];

   logic       new_item;
   logic [3:0] eff_pos;
   logic [7:0] run_eff;
   logic [7:0] cur_byte;
   logic       ends_step;
   logic       body_done;
   logic       advance;
   logic [3:0] adv_pos;
   logic       wr_en;
   logic       rd_en;
   logic [7:0] rd_addr;

   // An item starts at the first timestamp byte when it opens a packet,
   // otherwise directly at its payload byte.
   assign new_item  = (pos_ff == POS_START);
   assign eff_pos   = new_item ? (head.first ? 4'd0 : POS_DATA) : pos_ff;
   assign run_eff   = (new_item && head.first) ? 8'd0 : run_len_ff;
   assign cur_byte  = (eff_pos == POS_DATA) ? head.data
                                            : head.stamp[{3'd7 - eff_pos[2:0], 3'b000} +: 8];
   assign ends_step = (eff_pos == POS_DATA) && !head.last;
   assign body_done = ((rd_idx_ff + 8'd1) == flush_n_ff);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      run_len_in   = run_len_ff;
      full_sent_in = full_sent_ff;
      flush_n_in   = flush_n_ff;
      rd_idx_in    = rd_idx_ff;
      fin_in       = fin_ff;
      sym          = '0;
      pop          = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = 8'd0;
      advance      = 1'b0;
      adv_pos      = eff_pos;

      unique case (state_ff)
         ST_PUSH: begin
            if (fifo_valid) begin
               if (cur_byte == DELIM_BYTE) begin
                  // A zero byte closes the pending group: code first.
                  sym.valid    = 1'b1;
                  sym.has_byte = 1'b1;
                  sym.value    = run_eff + 8'd1;
                  sym.step_end = (run_eff == 8'd0) && ends_step;
                  if (pack_ready) begin
                     run_len_in   = 8'd0;
                     full_sent_in = 1'b0;
                     if (run_eff != 8'd0) begin
                        flush_n_in = run_eff;
                        rd_idx_in  = 8'd0;
                        rd_en      = 1'b1;
                        pos_in     = eff_pos;
                        state_in   = ST_BODY;
                     end else begin
                        advance = 1'b1;
                     end
                  end
               end else if (run_eff == RUN_LAST) begin
                  // The byte completes a maximal group, which leaves at once.
                  sym.valid    = 1'b1;
                  sym.has_byte = 1'b1;
                  sym.value    = FULL_CODE;
                  if (pack_ready) begin
                     wr_en        = 1'b1;
                     run_len_in   = 8'd0;
                     full_sent_in = 1'b1;
                     flush_n_in   = RUN_MAX;
                     rd_idx_in    = 8'd0;
                     rd_en        = 1'b1;
                     pos_in       = eff_pos;
                     state_in     = ST_BODY;
                  end
               end else begin
                  sym.valid    = ends_step;
                  sym.step_end = ends_step;
                  if (pack_ready || !ends_step) begin
                     wr_en        = 1'b1;
                     run_len_in   = run_eff + 8'd1;
                     full_sent_in = 1'b0;
                     advance      = 1'b1;
                  end
               end
            end
         end
         ST_BODY: begin
            sym.valid    = 1'b1;
            sym.has_byte = 1'b1;
            sym.value    = rd_data_ff;
            sym.step_end = body_done && !fin_ff && (pos_ff == POS_DATA) && !head.last;
            if (pack_ready) begin
               if (!body_done) begin
                  rd_en     = 1'b1;
                  rd_addr   = rd_idx_ff + 8'd1;
                  rd_idx_in = rd_idx_ff + 8'd1;
               end else if (fin_ff) begin
                  state_in = ST_DELIM;
               end else begin
                  adv_pos = pos_ff;
                  advance = 1'b1;
               end
            end
         end
         ST_FIN: begin
            if (!(full_sent_ff && (run_len_ff == 8'd0))) begin
               sym.valid    = 1'b1;
               sym.has_byte = 1'b1;
               sym.value    = run_len_ff + 8'd1;
               if (pack_ready) begin
                  run_len_in   = 8'd0;
                  full_sent_in = 1'b0;
                  if (run_len_ff != 8'd0) begin
                     flush_n_in = run_len_ff;
                     rd_idx_in  = 8'd0;
                     rd_en      = 1'b1;
                     fin_in     = 1'b1;
                     state_in   = ST_BODY;
                  end else begin
                     state_in = ST_DELIM;
                  end
               end
            end else begin
               // Right after a maximal group only the delimiter follows.
               sym.valid     = 1'b1;
               sym.has_byte  = 1'b1;
               sym.value     = DELIM_BYTE;
               sym.step_end  = 1'b1;
               sym.frame_end = 1'b1;
               if (pack_ready) begin
                  pop          = 1'b1;
                  pos_in       = POS_START;
                  run_len_in   = 8'd0;
                  full_sent_in = 1'b0;
                  state_in     = ST_PUSH;
               end
            end
         end
         ST_DELIM: begin
            sym.valid     = 1'b1;
            sym.has_byte  = 1'b1;
            sym.value     = DELIM_BYTE;
            sym.step_end  = 1'b1;
            sym.frame_end = 1'b1;
            if (pack_ready) begin
               pop      = 1'b1;
               pos_in   = POS_START;
               fin_in   = 1'b0;
               state_in = ST_PUSH;
            end
         end
         default: begin
            state_in = ST_PUSH;
         end
      endcase

      // Move on to the next byte of the item, to the frame close, or to
      // the next item.
      if (advance) begin
         if (adv_pos != POS_DATA) begin
            pos_in   = adv_pos + 4'd1;
            state_in = ST_PUSH;
         end else if (head.last) begin
            pos_in   = adv_pos;
            state_in = ST_FIN;
         end else begin
            pop      = 1'b1;
            pos_in   = POS_START;
            state_in = ST_PUSH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PUSH;
         pos_ff       <= POS_START;
         run_len_ff   <= 8'd0;
         full_sent_ff <= 1'b0;
         flush_n_ff   <= 8'd0;
         rd_idx_ff    <= 8'd0;
         fin_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         run_len_ff   <= run_len_in;
         full_sent_ff <= full_sent_in;
         flush_n_ff   <= flush_n_in;
         rd_idx_ff    <= rd_idx_in;
         fin_ff       <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         run_mem[run_eff] <= cur_byte;
      end
      if (rd_en) begin
         rd_data_ff <= run_mem[rd_addr];
      end
   end

   a_body_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BODY |-> rd_idx_ff < flush_n_ff)
      else $error("group read index ran past the group length");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_len_ff < RUN_MAX)
      else $error("run store holds a full group that was not flushed");

   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      full_sent_ff |-> run_len_ff == 8'd0)
      else $error("maximal group marked sent while bytes are pending");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> fifo_valid)
      else $error("queue popped while empty");

   a_body_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BODY && pack_ready && !body_done)
         |=> (state_ff == ST_BODY && rd_idx_ff == $past(rd_idx_ff) + 8'd1))
      else $error("group flush skipped or repeated a byte");

endmodule

// ----- sv/tscfe_pack.sv -----
`timescale 1ns / 1ps
// Output packer: gathers encoded bytes into words of up to eight and registers them.
module tscfe_pack (
   input  logic                     clock,
   input  logic                     reset,
   input  tscfe_pkg::tscfe_sym_type sym,
   output logic                     pack_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tscfe_pkg::tscfe_rsp_type rsp_payload
);
   import tscfe_pkg::*;

   logic [63:0]   acc_ff, acc_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   tscfe_rsp_type rsp_ff, rsp_in;

   logic [63:0] merged_acc;
   logic [3:0]  merged_cnt;
   logic        out_free;
   logic        load;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      merged_acc = acc_ff;
      merged_cnt = cnt_ff;
      if (sym.has_byte && (cnt_ff != CHUNK_BYTES)) begin
         merged_acc[{cnt_ff[2:0], 3'b000} +: 8] = sym.value;
         merged_cnt = cnt_ff + 4'd1;
      end
   end

   always_comb begin
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      rsp_in     = rsp_ff;
      load       = 1'b0;
      pack_ready = 1'b0;
      if (sym.valid) begin
         if ((cnt_ff == CHUNK_BYTES) && sym.has_byte) begin
            // A full word goes out once another byte is known to follow.
            if (out_free) begin
               load               = 1'b1;
               rsp_in.frame_bytes = acc_ff;
               rsp_in.byte_count  = cnt_ff;
               rsp_in.frame_end   = 1'b0;
               rsp_in.last_result = 1'b0;
               acc_in             = 64'd0;
               cnt_in             = 4'd0;
            end
         end else if (sym.step_end && (merged_cnt != 4'd0)) begin
            pack_ready = out_free;
            if (out_free) begin
               load               = 1'b1;
               rsp_in.frame_bytes = merged_acc;
               rsp_in.byte_count  = merged_cnt;
               rsp_in.frame_end   = sym.frame_end;
               rsp_in.last_result = 1'b1;
               acc_in             = 64'd0;
               cnt_in             = 4'd0;
            end
         end else begin
            pack_ready = 1'b1;
            acc_in     = merged_acc;
            cnt_in     = merged_cnt;
         end
      end
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 64'd0;
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- sv/timestamped_cobs_frame_encoder_unit.sv -----
`timescale 1ns / 1ps
// Top level of the timestamped COBS frame encoder.
// A request is first written into the queue; the back end and packer then act on the
// head, so the response register loads only after the queue entry has been written.
// The back end handles each byte fed to the encoder, each flushed byte, code and delimiter
// in a step of its own while the packer is ready; a packet's first request also feeds eight timestamp bytes.
// Reset clears the offset, packet state, queue and packer; the run store is not cleared.
module timestamped_cobs_frame_encoder_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tscfe_pkg::tscfe_req_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tscfe_pkg::tscfe_rsp_type rsp_payload,
   input  logic                     csr_write_en,
   input  logic signed [63:0]       csr_write_data
);
   import tscfe_pkg::*;

   // Front end to queue: requests that belong to an open packet, each
   // carrying the timestamp formed from the offset and the request's count.
   logic            q_push;
   logic            q_full;
   tscfe_entry_type q_entry;

   // Queue to back end.
   logic            head_valid;
   logic            head_pop;
   tscfe_entry_type head;

   // Back end to packer: one encoded byte or an end-of-request mark a cycle, held while the packer is not ready.
   tscfe_sym_type sym;
   logic          pack_ready;

   // The front end takes requests while the queue has room, so it keeps
   // accepting while the back end flushes a group or a response waits.
   tscfe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_payload    (req_payload),
      .req_stall      (req_stall),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   tscfe_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // The back end walks the timestamp bytes and the payload byte of the
   // request at the queue head, keeps the pending group in the run store
   // and streams each closed group out byte by byte.
   tscfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_valid (head_valid),
      .head       (head),
      .pop        (head_pop),
      .pack_ready (pack_ready),
      .sym        (sym)
   );

   // The packer groups the bytes of one request into words of up to eight
   // and holds each word in the response register until it is taken.
   tscfe_pack u_pack (
      .clock       (clock),
      .reset       (reset),
      .sym         (sym),
      .pack_ready  (pack_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- tb/tscfe_frame_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard that predicts the encoder's responses from the observed requests and checks them.
module tscfe_frame_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  tscfe_pkg::tscfe_req_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  tscfe_pkg::tscfe_rsp_type rsp_payload,
   input  logic                     csr_write_en,
   input  logic signed [63:0]       csr_write_data,
   output int                       fail_count,
   output int                       pending_count
);
   import tscfe_pkg::*;

   logic [63:0]   stamp_offset = '0;
   logic [7:0]    run_bytes [RUN_DEPTH];
   int unsigned   run_fill = 0;
   bit            packet_open = 1'b0;
   bit            full_group_last = 1'b0;
   logic [7:0]    coded_bytes [$];
   tscfe_rsp_type expected_chunks [$];
   int            mismatches = 0;

   function automatic void put_coded(input logic [7:0] value);
      if (coded_bytes.size() < 256) coded_bytes.push_back(value);
   endfunction

   function automatic void close_run();
      logic [7:0] code;
      code = 8'(run_fill + 1);
      put_coded(code);
      for (int i = 0; i < run_fill; i++) put_coded(run_bytes[i]);
      run_fill = 0;
      full_group_last = 1'b0;
   endfunction

   // A full run of nonzero bytes goes out at once behind the maximum code.
   function automatic void feed_byte(input logic [7:0] value);
      if (value == DELIM_BYTE) begin
         close_run();
      end else begin
         if (run_fill >= RUN_DEPTH) run_fill = 0;
         run_bytes[run_fill] = value;
         run_fill++;
         full_group_last = 1'b0;
         if (run_fill == RUN_DEPTH) begin
            put_coded(FULL_CODE);
            for (int i = 0; i < RUN_DEPTH; i++) put_coded(run_bytes[i]);
            run_fill = 0;
            full_group_last = 1'b1;
         end
      end
   endfunction

   function automatic void close_frame();
      if (!(full_group_last && run_fill == 0)) close_run();
      put_coded(DELIM_BYTE);
      run_fill = 0;
      full_group_last = 1'b0;
      packet_open = 1'b0;
   endfunction

   function automatic void encode_request(input tscfe_req_type r);
      logic [63:0]   stamp;
      tscfe_rsp_type chunk;
      int            n_chunks;
      int            n_bytes;
      coded_bytes.delete();
      if (r.first_byte) begin
         run_fill = 0;
         full_group_last = 1'b0;
         packet_open = (stamp_offset != '0);
         if (packet_open) begin
            stamp = stamp_offset + {32'h0, r.now_ms};
            for (int j = 0; j < 8; j++) feed_byte(stamp[63 - 8 * j -: 8]);
         end
      end
      if (packet_open) begin
         feed_byte(r.data_byte);
         if (r.last_byte) close_frame();
         n_chunks = (coded_bytes.size() + 7) / 8;
         for (int k = 0; k < n_chunks; k++) begin
            n_bytes = coded_bytes.size() - 8 * k;
            if (n_bytes > 8) n_bytes = 8;
            chunk = '0;
            for (int j = 0; j < n_bytes; j++) chunk.frame_bytes[8 * j +: 8] = coded_bytes[8 * k + j];
            chunk.byte_count  = n_bytes[3:0];
            chunk.frame_end   = r.last_byte && (k == n_chunks - 1);
            chunk.last_result = (k == n_chunks - 1);
            expected_chunks.push_back(chunk);
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t tscfe: %s expected %h got %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Responses are checked before the request of the same edge is predicted; the
   // block's latency keeps a request from answering at the edge that accepts it.
   always @(posedge clock) begin
      tscfe_rsp_type want;
      if (reset) begin
         stamp_offset = '0;
         run_fill = 0;
         packet_open = 1'b0;
         full_group_last = 1'b0;
         expected_chunks.delete();
      end else begin
         if (csr_write_en) stamp_offset = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_chunks.size() == 0) begin
               $display("%0t tscfe: no response expected, got %h", $time, rsp_payload);
               mismatches++;
            end else begin
               want = expected_chunks.pop_front();
               check_field("frame_bytes", want.frame_bytes, rsp_payload.frame_bytes);
               check_field("byte_count", 64'(want.byte_count), 64'(rsp_payload.byte_count));
               check_field("frame_end", 64'(want.frame_end), 64'(rsp_payload.frame_end));
               check_field("last_result", 64'(want.last_result),
                           64'(rsp_payload.last_result));
            end
         end
         if (req_valid && !req_stall) encode_request(req_payload);
      end
      fail_count    <= mismatches;
      pending_count <= expected_chunks.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Top of the encoder testbench: clock, reset, request and offset stimulus, and the verdict.
module tb;
   import tscfe_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   tscfe_req_type      req_payload;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   tscfe_rsp_type      rsp_payload;
   logic               csr_write_en;
   logic signed [63:0] csr_write_data;

   // Percentages of cycles in which the sender holds back and the receiver stalls.
   int tx_idle_pct = 38;
   int rx_idle_pct = 74;

   int fail_count;
   int pending_count;

   timestamped_cobs_frame_encoder_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   tscfe_frame_checker frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run: long packets flushing 32 responses
   // into a receiver that stalls most cycles, plus every drain between phases.
   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   // The receiver stalls at random; the rate follows the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // Payload bytes with a chosen share of zeros, which end COBS groups early.
   function automatic logic [7:0] next_byte(input int zero_pct);
      if ($urandom_range(99) < zero_pct) return 8'h00;
      return 8'($urandom_range(255, 1));
   endfunction

   // Offers one request and returns in the time step of the edge that accepts it. The
   // caller then either offers the next request or lowers valid in that same step, so
   // valid is never dropped and raised again within one step.
   task automatic send_req(input bit is_first, input bit is_last, input logic [7:0] data,
                           input logic [31:0] now_val);
      tscfe_req_type item;
      item.first_byte = is_first;
      item.last_byte  = is_last;
      item.data_byte  = data;
      item.now_ms     = now_val;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // A packet of len bytes; without close the packet is left open. The millisecond
   // count on the later bytes is random because the block must ignore it there.
   task automatic send_packet(input int len, input int zero_pct, input logic [31:0] now_val,
                              input bit close);
      for (int i = 0; i < len; i++)
         send_req(i == 0, close && i == len - 1, next_byte(zero_pct),
                  (i == 0) ? now_val : $urandom());
   endtask

   // Lets every predicted response arrive, then waits out requests that produce no
   // response but may still occupy the queue and the back end.
   task automatic wait_drained();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   // The offset is only written while the block is drained.
   task automatic write_offset(input logic [63:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Mostly well-formed packets with random content and zero density. The rest are
   // stray bytes, which are dropped outside a packet, and packets left open so that
   // the next first mark restarts inside a packet.
   task automatic random_traffic(input int budget);
      int sent;
      int pick;
      int len;
      int zero_pct;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(99);
         len  = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
         case ($urandom_range(2))
            0: zero_pct = 0;
            1: zero_pct = 15;
            default: zero_pct = 50;
         endcase
         if (pick < 70) begin
            send_packet(len, zero_pct, $urandom(), 1'b1);
            sent += len;
         end else if (pick < 85) begin
            repeat ($urandom_range(3, 1))
               send_req(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)), $urandom());
         end else begin
            len = $urandom_range(6, 1);
            send_packet(len, zero_pct, $urandom(), 1'b0);
            sent += len;
         end
      end
      // Close the phase on a complete packet.
      send_packet(3, 15, $urandom(), 1'b1);
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_payload    <= '0;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The offset is still zero after reset, so this packet is dropped as a whole,
      // including its closing byte. A byte with no packet open is ignored as well.
      send_req(1'b1, 1'b0, 8'h55, 32'h1234_5678);
      send_req(1'b0, 1'b1, 8'h00, 32'h0);
      send_req(1'b0, 1'b0, 8'hAA, 32'h0);
      wait_drained();

      // An offset of minus one with the largest count wraps the 64-bit timestamp.
      write_offset(64'hFFFF_FFFF_FFFF_FFFF);
      send_req(1'b1, 1'b0, 8'hFF, 32'hFFFF_FFFF);
      send_req(1'b0, 1'b0, 8'h00, 32'h0);
      send_req(1'b0, 1'b1, 8'h01, 32'h0);
      // A packet of one byte that is both first and last.
      send_req(1'b1, 1'b1, 8'h00, 32'h0);
      // A first mark inside an open packet drops the pending group and starts over.
      send_req(1'b1, 1'b0, 8'h11, 32'h8765_4321);
      send_req(1'b0, 1'b0, 8'h00, 32'h0);
      send_req(1'b1, 1'b0, 8'h22, 32'h0000_0001);
      send_req(1'b0, 1'b1, 8'h33, 32'h0);
      // A stray byte after the frame has been closed.
      send_req(1'b0, 1'b1, 8'h44, 32'hFFFF_FFFF);
      wait_drained();

      // Signed extremes of the offset.
      write_offset(64'h7FFF_FFFF_FFFF_FFFF);
      send_req(1'b1, 1'b1, 8'h80, 32'hFFFF_FFFF);
      wait_drained();
      write_offset(64'h8000_0000_0000_0000);
      send_req(1'b1, 1'b0, 8'h7F, 32'h8000_0000);
      send_req(1'b0, 1'b1, 8'hFF, 32'h0);
      wait_drained();

      // A timestamp that is almost all zero bytes, then a run of zero payload bytes.
      write_offset(64'h1);
      send_req(1'b1, 1'b0, 8'h01, 32'h0);
      send_req(1'b0, 1'b0, 8'h00, 32'h0);
      send_req(1'b0, 1'b0, 8'h00, 32'h0);
      send_req(1'b0, 1'b1, 8'h00, 32'h0);
      wait_drained();

      // Setting the offset back to zero disables logging again.
      write_offset(64'h0);
      send_req(1'b1, 1'b1, 8'hFF, 32'hFFFF_FFFF);
      wait_drained();

      // Phase one: the sender idles now and then, the receiver stalls most cycles. With
      // every timestamp byte nonzero, 246 nonzero payload bytes complete a full group
      // on the packet's last byte, so only the delimiter may follow it.
      write_offset(64'h0101_0101_0101_0101);
      send_packet(246, 0, 32'h0101_0101, 1'b1);
      random_traffic(45);
      wait_drained();

      // Phase two: the roles swap, and a small offset puts zeros into the timestamps.
      tx_idle_pct <= 74;
      rx_idle_pct <= 38;
      write_offset(64'($urandom_range(5000, 1)));
      random_traffic(45);
      wait_drained();

      // Phase three: no idling at all and a random nonzero offset.
      tx_idle_pct <= 0;
      rx_idle_pct <= 0;
      write_offset({$urandom(), $urandom()} | 64'h1);
      random_traffic(45);
      wait_drained();

      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
